>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, sampled on the rising clock edge, off in reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

>>> rtl/ess_pkg.sv
// Shared constants and controller/datapath interface types for the ESS block.
`default_nettype none

package ess_pkg;

   localparam int WEIGHT_W           = 16;
   localparam int SQ_W               = 2 * WEIGHT_W;
   localparam int SUM_W              = 48;
   localparam int SQ_FRAC_BITS       = 30;
   localparam int ESS_W              = 24;
   localparam int ESS_FRAC_BITS_DFLT = 8;
   localparam int DIV_STEPS          = ESS_W;
   localparam int CNT_W              = $clog2(DIV_STEPS);

   // controller -> datapath
   typedef struct packed {
      logic accept;    // weight word taken this cycle
      logic check;     // latch divisor, classify sum, clear accumulator
      logic step;      // one restoring division step
      logic load_out;  // move result into the output register
   } ess_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic zero;      // sum of squares is zero
      logic big;       // quotient would exceed the maximum code
   } ess_sts_type;

endpackage

`default_nettype wire

>>> rtl/effective_sample_size.sv
// Top level: Kish effective sample size of a stream of normalised weights.
//
//  channel | dir | tdata                  | tuser        | tlast
//  req_    | in  | [15:0] weight Q1.15    | -            | last weight of set
//  rsp_    | out | [23:0] ess Q(24-F).F   | [0] zero_sum | -
//
// Weight words are taken one per cycle while accumulating; each is squared,
// registered, then added to a 48-bit saturating sum of squares.
// After the word marked last, req_tready drops while the sum is classified,
// divided unless zero or saturating (restoring divider, one quotient bit per
// cycle), and while the result waits for the output register.
// The result word is held in an output register until rsp_tready takes it.
// Synchronous reset clears the sum, the controller and rsp_tvalid.
`default_nettype none
`include "assert_macros.svh"

module effective_sample_size
   import ess_pkg::*;
#(
   parameter int ESS_FRAC_BITS = ESS_FRAC_BITS_DFLT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output      logic                req_tready,
   input  wire logic [WEIGHT_W-1:0] req_tdata,   // [15:0] weight
   input  wire logic                req_tlast,
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [ESS_W-1:0]    rsp_tdata,   // [23:0] ess
   output      logic [0:0]          rsp_tuser    // [0] zero_sum
);

   localparam logic [ESS_W-1:0] ESS_ONE = {{(ESS_W-1){1'b0}}, 1'b1} << ESS_FRAC_BITS;

   ess_cmd_type cmd;
   ess_sts_type sts;
   logic        zero_sum;

   // sequencing only; no payload passes through here
   ess_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_last   (req_tlast),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // square, accumulate and divide under controller commands
   ess_dp #(
      .ESS_FRAC_BITS (ESS_FRAC_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .weight   (req_tdata),
      .ess      (rsp_tdata),
      .zero_sum (zero_sum)
   );

   assign rsp_tuser = zero_sum;

   // a zero sum must always report exactly 1.0
   `ASSERT_CLK(a_zero_is_one, $rose(rsp_tvalid) && rsp_tuser[0] |-> rsp_tdata == ESS_ONE, "zero sum without 1.0")
   // the last weight of a set stops intake while the result is worked out
   `ASSERT_CLK(a_last_stalls, req_tvalid && req_tready && req_tlast |=> !req_tready, "intake after last")
   // never overwrite a result word that is still waiting
   `ASSERT_NEVER(a_no_overwrite, cmd.load_out && rsp_tvalid && !rsp_tready, "result overwritten")

endmodule

`default_nettype wire

>>> rtl/ess_dp.sv
// Datapath: squarer, saturating accumulator, iterative divider, output register.
`default_nettype none

module ess_dp
   import ess_pkg::*;
#(
   parameter int ESS_FRAC_BITS = ESS_FRAC_BITS_DFLT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ess_cmd_type         cmd,
   output      ess_sts_type         sts,
   input  wire logic [WEIGHT_W-1:0] weight,
   output      logic [ESS_W-1:0]    ess,
   output      logic                zero_sum
);

   // quotient reaches 2^ESS_W exactly when sum <= 2^(30+F-24)
   localparam logic [SUM_W-1:0] SAT_LIMIT =
      {{(SUM_W-1){1'b0}}, 1'b1} << (SQ_FRAC_BITS + ESS_FRAC_BITS - ESS_W);
   localparam logic [ESS_W-1:0] ESS_ONE = {{(ESS_W-1){1'b0}}, 1'b1} << ESS_FRAC_BITS;
   localparam logic [ESS_W-1:0] ESS_MAX = '1;

   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic             sq_vld_ff;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SUM_W:0]   sum_ext;
   logic [SUM_W-1:0] div_ff, rem_ff, rem_in;
   logic [SUM_W:0]   rem_sh, rem_diff;
   logic [ESS_W-1:0] quo_ff, quo_in;
   logic             zero_ff;
   logic [ESS_W-1:0] ess_ff;
   logic             flag_ff;

   assign sq_in   = SQ_W'(weight) * SQ_W'(weight);
   assign sum_ext = {1'b0, sum_ff} + (SUM_W+1)'(sq_ff);

   assign sts.zero = (sum_ff == '0);
   assign sts.big  = (sum_ff <= SAT_LIMIT);

   always_comb begin
      sum_in = sum_ff;
      if (cmd.check) begin
         sum_in = '0;
      end else if (sq_vld_ff) begin
         sum_in = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      end
   end

   // shift remainder, subtract divisor where it fits
   assign rem_sh   = {rem_ff, 1'b0};
   assign rem_diff = rem_sh - {1'b0, div_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.check) begin
         rem_in = SAT_LIMIT;
         quo_in = sts.zero ? ESS_ONE : ESS_MAX;
      end else if (cmd.step) begin
         if (!rem_diff[SUM_W]) begin
            rem_in = rem_diff[SUM_W-1:0];
            quo_in = {quo_ff[ESS_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[SUM_W-1:0];
            quo_in = {quo_ff[ESS_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
         sum_ff    <= '0;
      end else begin
         sq_vld_ff <= cmd.accept;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sq_ff <= sq_in;
      end
      if (cmd.check) begin
         div_ff  <= sum_ff;
         zero_ff <= sts.zero;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.load_out) begin
         ess_ff  <= quo_ff;
         flag_ff <= zero_ff;
      end
   end

   assign ess      = ess_ff;
   assign zero_sum = flag_ff;

endmodule

`default_nettype wire

>>> rtl/ess_ctrl.sv
// Controller: sequences accumulate, classify, divide and result hand-off.
`default_nettype none

module ess_ctrl
   import ess_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire logic        in_last,
   output      logic        in_ready,
   output      logic        out_valid,
   input  wire logic        out_ready,
   output      ess_cmd_type cmd,
   input  wire ess_sts_type sts
);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_DRAIN,
      ST_CHECK,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             out_valid_ff;
   logic             out_free;

   assign in_ready  = (state_ff == ST_ACCUM);
   assign out_valid = out_valid_ff;
   assign out_free  = !out_valid_ff || out_ready;

   always_comb begin
      cmd          = '0;
      cmd.accept   = in_ready && in_valid;
      cmd.check    = (state_ff == ST_CHECK);
      cmd.step     = (state_ff == ST_DIVIDE);
      cmd.load_out = (state_ff == ST_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_ACCUM: begin
               if (cmd.accept && in_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               cnt_ff <= CNT_W'(DIV_STEPS - 1);
               if (sts.zero || sts.big) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (cnt_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  state_ff <= ST_ACCUM;
               end
            end
            default: begin
               state_ff <= ST_ACCUM;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
